FILE: rtl/qet_pkg.sv
// ----------------------------------------------------------------------------
// qet_pkg
// Shared widths, constants and function codes for the quadrature encoder
// tracker and its serial arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package qet_pkg;

	// field widths
	localparam int TIME_W   = 32;
	localparam int CPR_W    = 16;
	localparam int MOD_W    = CPR_W + 1;    // modulus 2*cpr, up to 65536
	localparam int POS_W    = 16;
	localparam int SPEED_W  = 32;
	localparam int ANGLE_W  = 19;
	localparam int FUNC_W   = 2;

	// serial multiplier: a is up to 35 bits, b up to 17 bits
	localparam int MUL_A_W   = 35;
	localparam int MUL_B_W   = MOD_W;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

	// serial divider: partial remainder and dividend digit register
	localparam int DIV_R_W   = 46;
	localparam int DIV_N_W   = 28;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

	// iteration counts of the divider jobs
	localparam logic [DIV_CNT_W-1:0] DIV_IT_SPEED = DIV_CNT_W'(DIV_N_W);
	localparam logic [DIV_CNT_W-1:0] DIV_IT_ANGLE = DIV_CNT_W'(ANGLE_W);
	localparam logic [DIV_CNT_W-1:0] DIV_IT_MOD   = DIV_CNT_W'(MOD_W);

	// arithmetic constants
	localparam logic [MUL_A_W-1:0] TWO_PI_Q32  = 35'd26986075409;
	localparam logic [DIV_N_W-1:0] SPEED_NUM   = 28'd256000000;
	localparam logic [PROD_W-1:0]  STOP_LIMIT  = PROD_W'(100000000);
	localparam logic [SPEED_W-1:0] SPEED_SAT   = '1;
	localparam logic [CPR_W-1:0]   CPR_RESET   = 16'd1024;
	localparam logic [CPR_W-1:0]   CPR_MAX     = 16'd32768;
	localparam logic [CPR_W-1:0]   CPR_MIN     = 16'd1;

	// event codes
	localparam logic [FUNC_W-1:0] FUNC_EDGE_A = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_EDGE_B = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/qet_mul.sv
// ----------------------------------------------------------------------------
// qet_mul
// Bit-serial shift-add multiplier: one multiplier bit per cycle over the
// MUL_B_W bits of b. Product holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module qet_mul (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [qet_pkg::MUL_A_W-1:0] a,
	input  wire logic [qet_pkg::MUL_B_W-1:0] b,
	output logic                            busy,
	output logic [qet_pkg::PROD_W-1:0]      prod
);
	import qet_pkg::*;

	localparam int HI_W = MUL_A_W + 1;

	logic [MUL_CNT_W-1:0]      cnt_q;
	logic [MUL_A_W-1:0]        a_q;
	logic [HI_W+MUL_B_W-1:0]   p_q;
	logic [HI_W-1:0]           sum;

	// upper half accumulates a when the low bit of the multiplier is set
	always_comb begin
		sum = p_q[HI_W+MUL_B_W-1:MUL_B_W] + (p_q[0] ? {1'b0, a_q} : '0);
	end

	// iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= MUL_CNT_W'(MUL_B_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// product shift register
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{HI_W{1'b0}}, b};
		end else if (cnt_q != '0) begin
			p_q <= {1'b0, sum, p_q[MUL_B_W-1:1]};
		end
	end

	assign busy = (cnt_q != '0);
	assign prod = p_q[PROD_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/qet_div.sv
// ----------------------------------------------------------------------------
// qet_div
// Restoring radix-2 divider: one quotient bit per cycle. Dividend bits are
// shifted in MSB first from a left-aligned register; the partial remainder
// may be preloaded. Quotient bits shift into the low bits while the 'iters' count runs down.
// ----------------------------------------------------------------------------
`default_nettype none

module qet_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [qet_pkg::DIV_CNT_W-1:0] iters,
	input  wire logic [qet_pkg::DIV_R_W-1:0]   rem_init,
	input  wire logic [qet_pkg::DIV_N_W-1:0]   num,
	input  wire logic [qet_pkg::DIV_R_W-1:0]   divisor,
	output logic                              busy,
	output logic [qet_pkg::DIV_N_W-1:0]       quot,
	output logic [qet_pkg::DIV_R_W-1:0]       rem
);
	import qet_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_R_W-1:0]   rem_q;
	logic [DIV_R_W-1:0]   div_q;
	logic [DIV_N_W-1:0]   num_q;
	logic [DIV_N_W-1:0]   quot_q;
	logic [DIV_R_W:0]     trial;
	logic [DIV_R_W:0]     diff;
	logic                 fits;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, num_q[DIV_N_W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = (trial >= {1'b0, div_q});
	end

	// iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= iters;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// remainder, dividend and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			div_q  <= divisor;
			num_q  <= num;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q  <= fits ? diff[DIV_R_W-1:0] : trial[DIV_R_W-1:0];
			num_q  <= {num_q[DIV_N_W-2:0], 1'b0};
			quot_q <= {quot_q[DIV_N_W-2:0], fits};
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/quadrature_encoder_tracker_core.sv
// An edge request runs the serial multiply and then the division before its result
// is valid, with a modulus division first when the stored position is at or above
// the modulus after a lowered CPR; a status read runs the multiply only, an unused
// code neither. One request at a time: in_ready is high only while idle.
// Reset: arst_n clears direction, position, timestamp, speed and angle and sets
// counts_per_rev to 1024; no clearing pass.
// ----------------------------------------------------------------------------
// quadrature_encoder_tracker_core
// Quadrature edge tracker: direction, position modulo 2*CPR, speed in rev/s
// (Q24.8) and angle in radians (Q3.16), with a stop test on status reads.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_encoder_tracker_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [qet_pkg::CPR_W-1:0]   counts_per_rev,
	// request
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [qet_pkg::FUNC_W-1:0]  func,
	input  wire logic                        level_a,
	input  wire logic                        level_b,
	input  wire logic [qet_pkg::TIME_W-1:0]  now_us,
	// result
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             dir_ccw,
	output logic [qet_pkg::POS_W-1:0]        position,
	output logic [qet_pkg::SPEED_W-1:0]      speed_q8,
	output logic [qet_pkg::ANGLE_W-1:0]      angle_q16,
	output logic                             stopped
);
	import qet_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_POS  = 3'd1;
	localparam logic [2:0] ST_MOD  = 3'd2;
	localparam logic [2:0] ST_GO   = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]         state_q;
	logic [CPR_W-1:0]   cpr_q;
	logic [MOD_W-1:0]   mod_q;
	logic               edge_q;
	logic               status_q;
	logic               cw_q;
	logic [TIME_W-1:0]  delta_q;
	logic               spd_run_q;
	logic               stop_q;

	logic               dir_q;
	logic [POS_W-1:0]   pos_q;
	logic [TIME_W-1:0]  last_q;
	logic [SPEED_W-1:0] speed_q;
	logic [ANGLE_W-1:0] angle_q;

	logic               out_valid_q;
	logic               out_dir_q;
	logic [POS_W-1:0]   out_pos_q;
	logic [SPEED_W-1:0] out_speed_q;
	logic [ANGLE_W-1:0] out_angle_q;
	logic               out_stop_q;

	logic               accept;
	logic [CPR_W-1:0]   cpr_eff;
	logic [MOD_W-1:0]   mod_now;
	logic               in_edge;
	logic               in_cw;
	logic [MOD_W-1:0]   pos_ext;
	logic [MOD_W-1:0]   pos_step;
	logic [POS_W-1:0]   pos_fast;

	logic               mul_start;
	logic               mul_d_busy;
	logic               mul_k_busy;
	logic [PROD_W-1:0]  prod_d;
	logic [PROD_W-1:0]  prod_k;

	logic               dspd_start;
	logic               dspd_busy;
	logic [DIV_N_W-1:0] dspd_quot;
	logic [DIV_R_W-1:0] dspd_rem;

	logic                 dang_start;
	logic [DIV_CNT_W-1:0] dang_iters;
	logic [DIV_R_W-1:0]   dang_rem_init;
	logic [DIV_N_W-1:0]   dang_num;
	logic                 dang_busy;
	logic [DIV_N_W-1:0]   dang_quot;
	logic [DIV_R_W-1:0]   dang_rem;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;

	// clamp CPR to 1..32768, modulus is twice that
	always_comb begin
		if (cpr_q == '0) begin
			cpr_eff = CPR_MIN;
		end else if (cpr_q > CPR_MAX) begin
			cpr_eff = CPR_MAX;
		end else begin
			cpr_eff = cpr_q;
		end
		mod_now = {cpr_eff, 1'b0};
	end

	// direction from levels: A edge is clockwise on equal levels, B on differing
	always_comb begin
		in_edge = (func == FUNC_EDGE_A) || (func == FUNC_EDGE_B);
		in_cw   = (func == FUNC_EDGE_A) ? (level_a == level_b) : (level_a != level_b);
	end

	// position step: fast path when the count is already below the modulus
	always_comb begin
		pos_ext  = {1'b0, pos_q};
		pos_step = cw_q ? (pos_ext + 1'b1) : (pos_ext - 1'b1);
		if (cw_q) begin
			pos_fast = (pos_step == mod_q) ? '0 : pos_step[POS_W-1:0];
		end else begin
			pos_fast = (pos_q == '0) ? POS_W'(mod_q - 1'b1) : pos_step[POS_W-1:0];
		end
	end

	// serial multipliers: M*delta and position*2pi
	assign mul_start = (state_q == ST_GO);

	qet_mul u_mul_d (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (MUL_A_W'(delta_q)),
		.b      (mod_q),
		.busy   (mul_d_busy),
		.prod   (prod_d)
	);

	qet_mul u_mul_k (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (TWO_PI_Q32),
		.b      (pos_ext),
		.busy   (mul_k_busy),
		.prod   (prod_k)
	);

	// speed divider: 256e6 / (M*delta)
	assign dspd_start = (state_q == ST_MUL) && !mul_d_busy && edge_q &&
		(delta_q != '0) && (delta_q < TIME_W'(SPEED_NUM));

	qet_div u_div_spd (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dspd_start),
		.iters    (DIV_IT_SPEED),
		.rem_init ('0),
		.num      (SPEED_NUM),
		.divisor  (prod_d[DIV_R_W-1:0]),
		.busy     (dspd_busy),
		.quot     (dspd_quot),
		.rem      (dspd_rem)
	);

	// shared divider: position reduction, then angle = (pos*K >> 16) / M
	always_comb begin
		if (state_q == ST_POS) begin
			dang_start    = edge_q && (pos_ext >= mod_q);
			dang_iters    = DIV_IT_MOD;
			dang_rem_init = '0;
			dang_num      = {pos_step, {(DIV_N_W-MOD_W){1'b0}}};
		end else begin
			dang_start    = (state_q == ST_MUL) && !mul_k_busy && edge_q;
			dang_iters    = DIV_IT_ANGLE;
			dang_rem_init = DIV_R_W'(prod_k[PROD_W-1:ANGLE_W+16]);
			dang_num      = {prod_k[ANGLE_W+15:16], {(DIV_N_W-ANGLE_W){1'b0}}};
		end
	end

	qet_div u_div_ang (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dang_start),
		.iters    (dang_iters),
		.rem_init (dang_rem_init),
		.num      (dang_num),
		.divisor  (DIV_R_W'(mod_q)),
		.busy     (dang_busy),
		.quot     (dang_quot),
		.rem      (dang_rem)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q <= CPR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cpr_q <= counts_per_rev;
		end
	end

	// sequencer and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dir_q     <= 1'b0;
			pos_q     <= '0;
			last_q    <= '0;
			speed_q   <= '0;
			angle_q   <= '0;
			edge_q    <= 1'b0;
			status_q  <= 1'b0;
			cw_q      <= 1'b0;
			delta_q   <= '0;
			mod_q     <= '0;
			spd_run_q <= 1'b0;
			stop_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						edge_q    <= in_edge;
						status_q  <= (func == FUNC_STATUS);
						cw_q      <= in_cw;
						delta_q   <= now_us - last_q;
						mod_q     <= mod_now;
						spd_run_q <= 1'b0;
						stop_q    <= 1'b0;
						if (in_edge) begin
							last_q <= now_us;
						end
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					if (edge_q) begin
						dir_q <= !cw_q;
						if (pos_ext >= mod_q) begin
							state_q <= ST_MOD;
						end else begin
							pos_q   <= pos_fast;
							state_q <= ST_GO;
						end
					end else if (status_q) begin
						state_q <= ST_GO;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_MOD: begin
					if (!dang_busy) begin
						pos_q   <= dang_rem[POS_W-1:0];
						state_q <= ST_GO;
					end
				end
				ST_GO: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (!mul_d_busy) begin
						if (edge_q) begin
							if (delta_q == '0) begin
								speed_q <= SPEED_SAT;
							end else if (!dspd_start) begin
								speed_q <= '0;
							end
							spd_run_q <= dspd_start;
							state_q   <= ST_DIV;
						end else begin
							// status read: stop when M*delta exceeds 1e8
							if ((delta_q != '0) && (prod_d > STOP_LIMIT)) begin
								speed_q <= '0;
								stop_q  <= 1'b1;
							end
							state_q <= ST_DONE;
						end
					end
				end
				ST_DIV: begin
					if (!dspd_busy && !dang_busy) begin
						if (spd_run_q) begin
							speed_q <= SPEED_W'(dspd_quot);
						end
						angle_q <= dang_quot[ANGLE_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid_q || out_ready)) begin
			out_dir_q   <= dir_q;
			out_pos_q   <= pos_q;
			out_speed_q <= speed_q;
			out_angle_q <= angle_q;
			out_stop_q  <= stop_q;
		end
	end

	assign out_valid = out_valid_q;
	assign dir_ccw   = out_dir_q;
	assign position  = out_pos_q;
	assign speed_q8  = out_speed_q;
	assign angle_q16 = out_angle_q;
	assign stopped   = out_stop_q;

endmodule

`default_nettype wire
